// ===== rtl/iol_pkg.sv =====
package iol_pkg;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LEFT,
        SEL_RIGHT,
        SEL_LOAD
    } t_cell_sel;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

endpackage

// ===== rtl/iol_cell.sv =====
module iol_cell
    import iol_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_sel          i_sel,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    input  logic signed [31:0] i_load,
    output logic signed [31:0] o_q
);

    logic signed [31:0] r_q;
    logic signed [31:0] n_q;

    always_comb begin
        unique case (i_sel)
            SEL_HOLD:  n_q = r_q;
            SEL_LEFT:  n_q = i_left;
            SEL_RIGHT: n_q = i_right;
            SEL_LOAD:  n_q = i_load;
            default:   n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== rtl/indexed_ordered_list.sv =====
// Channel   Direction  Handshake                  Payload
// request   in         i_start, o_busy            i_mode, i_position, i_value
// result    out        o_strobe (one cycle each)  o_entry_value, o_entry_index, o_status,
//                                                 o_entry_count, o_list_empty, o_last
//
// At acceptance the cell chain shifts once; the dump state then rotates it
// once per cycle through all DEPTH cells while cell 0 is reported.
// Results appear for the entries in index order, or once for an empty list.
// Reset is synchronous and active low; it clears the entry count and the controller.
// The receiver cannot stall; o_busy holds off new requests until the rotation ends.
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_mode,
    input  logic [15:0]        i_position,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic signed [31:0] o_entry_value,
    output logic [3:0]         o_entry_index,
    output logic [1:0]         o_status,
    output logic [4:0]         o_entry_count,
    output logic               o_list_empty,
    output logic               o_last
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state          r_state, n_state;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_status, n_status;

    t_cell_sel          sel   [DEPTH];
    logic signed [31:0] q     [DEPTH];
    logic signed [31:0] left  [DEPTH];
    logic signed [31:0] right [DEPTH];

    logic            accept;
    logic [15:0]     count_ext;
    logic [CW-1:0]   pos_c;
    logic [CW-1:0]   cnt_ext;
    logic [IW+3:0]   idx_wide;
    logic [CW+4:0]   count_wide;

    assign accept    = i_start && (r_state == S_IDLE);
    assign count_ext = 16'(r_count);
    assign cnt_ext   = CW'(r_cnt);

    // Clamp the position to the list end for the requested operation.
    always_comb begin
        if (i_mode == MODE_INSERT) begin
            pos_c = (i_position > count_ext) ? r_count : i_position[CW-1:0];
        end else begin
            pos_c = (i_position >= count_ext) ? (r_count - CW'(1)) : i_position[CW-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            sel[i] = SEL_HOLD;
            if (r_state == S_DUMP) begin
                sel[i] = SEL_RIGHT;
            end else if (accept) begin
                if (i_mode == MODE_INSERT && r_count != CW'(DEPTH)) begin
                    if (CW'(i) > pos_c) begin
                        sel[i] = SEL_LEFT;
                    end else if (CW'(i) == pos_c) begin
                        sel[i] = SEL_LOAD;
                    end
                end else if (i_mode == MODE_REMOVE && r_count != '0) begin
                    if (CW'(i) >= pos_c) begin
                        sel[i] = SEL_RIGHT;
                    end
                end
            end
        end
    end

    // The last cell's right neighbor is cell 0, which closes the ring for the dump.
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign left[g] = i_value;
            end else begin : g_body
                assign left[g] = q[g-1];
            end
            assign right[g] = q[(g + 1) % DEPTH];

            iol_cell u_cell (
                .i_clk   (i_clk),
                .i_sel   (sel[g]),
                .i_left  (left[g]),
                .i_right (right[g]),
                .i_load  (i_value),
                .o_q     (q[g])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_count  = r_count;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state  = S_DUMP;
                    n_cnt    = '0;
                    n_status = STAT_DONE;
                    if (i_mode == MODE_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            S_DUMP: begin
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == IW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_count  <= '0;
            r_status <= STAT_DONE;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign idx_wide   = {4'b0, r_cnt};
    assign count_wide = {5'b0, r_count};

    always_comb begin
        o_busy        = 1'b0;
        o_strobe      = 1'b0;
        o_list_empty  = (r_count == '0);
        o_last        = 1'b0;
        o_entry_value = q[0];
        o_entry_index = idx_wide[3:0];
        o_status      = r_status;
        o_entry_count = count_wide[4:0];
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
            end
            S_DUMP: begin
                o_busy = 1'b1;
                if (r_count == '0) begin
                    o_strobe      = (r_cnt == '0);
                    o_last        = 1'b1;
                    o_entry_value = '0;
                end else begin
                    o_strobe = (cnt_ext < r_count);
                    o_last   = (cnt_ext == r_count - CW'(1));
                end
            end
            default: o_busy = 1'b0;
        endcase
    end

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result strobe outside a dump");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && o_strobe && o_entry_index == 4'd0))
        else $error("accepted request did not start its report");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_list_empty) |-> o_last)
        else $error("empty report not marked last");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result after the last one of a report");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

endmodule

// ===== tb/tb_indexed_ordered_list.sv =====
`timescale 1ns / 100ps

module tb_indexed_ordered_list;
    import iol_pkg::*;

    localparam int DEPTH           = 16;
    localparam int CLK_HALF        = 10;
    localparam int RANDOM_REQUESTS = 300;
    localparam int DRAIN_LIMIT     = 4000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic [1:0]         status;
        logic [4:0]         count;
        logic               empty;
        logic               last;
    } t_dump_rec;

    class ordered_list_tracker;
        logic signed [31:0] slots [DEPTH];
        int                 fill;
        t_dump_rec          expected_dump [$];
        int                 errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_dump.size();
        endfunction

        // Applies one accepted request to the list and queues the dump it causes.
        function void note_request(logic mode, logic [15:0] pos, logic signed [31:0] val);
            int        at;
            int        i;
            logic [1:0] st;
            t_dump_rec rec;
            st = STAT_DONE;
            at = pos;
            if (mode == MODE_INSERT) begin
                if (fill >= DEPTH) begin
                    st = STAT_FULL;
                end else begin
                    if (at > fill) at = fill;
                    for (i = fill; i > at; i--) slots[i] = slots[i - 1];
                    slots[at] = val;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    if (at >= fill) at = fill - 1;
                    for (i = at; i + 1 < fill; i++) slots[i] = slots[i + 1];
                    fill--;
                end
            end
            if (fill == 0) begin
                rec = '{value: '0, index: '0, status: st, count: '0, empty: 1'b1, last: 1'b1};
                expected_dump.push_back(rec);
            end else begin
                for (i = 0; i < fill; i++) begin
                    rec.value  = slots[i];
                    rec.index  = i[3:0];
                    rec.status = st;
                    rec.count  = fill[4:0];
                    rec.empty  = 1'b0;
                    rec.last   = (i == fill - 1);
                    expected_dump.push_back(rec);
                end
            end
        endfunction

        function void field_check(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (act_val !== exp_val) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(t_dump_rec got);
            t_dump_rec exp_rec;
            if (expected_dump.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0h index %0d",
                         $time, got.value, got.index);
                errors++;
                return;
            end
            exp_rec = expected_dump.pop_front();
            field_check("entry_value", exp_rec.value, got.value);
            field_check("entry_index", exp_rec.index, got.index);
            field_check("status", exp_rec.status, got.status);
            field_check("entry_count", exp_rec.count, got.count);
            field_check("list_empty", exp_rec.empty, got.empty);
            field_check("last", exp_rec.last, got.last);
        endfunction

        function void report_leftovers();
            t_dump_rec rec;
            while (expected_dump.size() != 0) begin
                rec = expected_dump.pop_front();
                $display("%0t: missing result, expected value %0h index %0d, actual none",
                         $time, rec.value, rec.index);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_mode;
    logic [15:0]        i_position;
    logic signed [31:0] i_value;
    logic               o_strobe;
    logic signed [31:0] o_entry_value;
    logic [3:0]         o_entry_index;
    logic [1:0]         o_status;
    logic [4:0]         o_entry_count;
    logic               o_list_empty;
    logic               o_last;

    ordered_list_tracker tracker = new();

    indexed_ordered_list #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_entry_value(o_entry_value),
        .o_entry_index(o_entry_index),
        .o_status     (o_status),
        .o_entry_count(o_entry_count),
        .o_list_empty (o_list_empty),
        .o_last       (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : result_monitor
        t_dump_rec seen;
        if (i_rst_n && o_strobe === 1'b1) begin
            seen = '{value: o_entry_value, index: o_entry_index, status: o_status,
                     count: o_entry_count, empty: o_list_empty, last: o_last};
            tracker.check_result(seen);
        end
    end

    // Start stays high across back-to-back requests; the request is taken
    // at the first rising edge with busy low.
    task automatic send_request(logic mode, logic [15:0] pos, logic signed [31:0] val);
        @(negedge i_clk);
        i_start    = 1'b1;
        i_mode     = mode;
        i_position = pos;
        i_value    = val;
        do @(posedge i_clk); while (o_busy);
        tracker.note_request(mode, pos, val);
    endtask

    task automatic idle_for(int cycles);
        @(negedge i_clk);
        i_start = 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int waited;
        @(negedge i_clk);
        i_start = 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && tracker.pending() != 0; waited++)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_position(int fill);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'(fill);
            2:       return (fill == 0) ? 16'd0 : 16'(fill - 1);
            3:       return 16'($urandom_range(0, fill + 1));
            4:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int   sent;
        int   burst;
        int   k;
        int   insert_pct;
        bit   mid_drain_done;
        logic mode;

        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_mode     = MODE_INSERT;
        i_position = '0;
        i_value    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Removes from an empty list, then inserts at the head, past the end,
        // at the last index and exactly at the end.
        send_request(MODE_REMOVE, 16'd0, 32'h1234_5678);
        send_request(MODE_REMOVE, 16'hFFFF, 32'h0);
        send_request(MODE_INSERT, 16'd0, 32'h8000_0000);
        send_request(MODE_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
        send_request(MODE_INSERT, 16'd1, 32'h0);
        send_request(MODE_INSERT, 16'd3, 32'hFFFF_FFFF);
        while (tracker.fill < DEPTH)
            send_request(MODE_INSERT, pick_position(tracker.fill), pick_value());
        send_request(MODE_INSERT, 16'd0, 32'h5555_5555);
        send_request(MODE_INSERT, 16'hFFFF, 32'hAAAA_AAAA);
        send_request(MODE_REMOVE, 16'd0, 32'h0);
        send_request(MODE_REMOVE, 16'hFFFF, 32'h0);
        send_request(MODE_REMOVE, 16'(tracker.fill - 1), 32'h0);
        send_request(MODE_REMOVE, 16'd5, 32'h0);
        wait_drained();

        // The insert share drifts so the list walks between empty and full.
        sent           = 0;
        insert_pct     = 50;
        mid_drain_done = 1'b0;
        while (sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            burst = $urandom_range(1, 8);
            for (k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
                mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
                send_request(mode, pick_position(tracker.fill), pick_value());
                sent++;
            end
            if (!mid_drain_done && sent >= RANDOM_REQUESTS / 2) begin
                wait_drained();
                mid_drain_done = 1'b1;
            end else if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 30));
            end
        end

        wait_drained();
        repeat (DEPTH + 4) @(posedge i_clk);
        tracker.report_leftovers();
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
